// File: rtl/cts_pkg.sv
// Shared types, constants and sign-pattern table for the clover-term site multiply.
package cts_pkg;

  localparam int DATA_W    = 32;   // stored operand width
  localparam int VALUE_W   = 32;   // result value width
  localparam int FRAC_W    = 24;   // default fraction bits
  localparam int ACC_W     = 72;   // exact sum of 72 signed 64-bit products
  localparam int MUL_W     = (((VALUE_W > DATA_W) ? VALUE_W : DATA_W) + 7) / 8 * 8;
  localparam int RND_W     = (ACC_W > 2 * MUL_W) ? ACC_W : 2 * MUL_W;

  localparam int NUM_MAT   = 6;
  localparam int MAT_SIZE  = 18;
  localparam int ROW_SIZE  = 6;
  localparam int SPIN_SIZE = 24;
  localparam int FADDR_W   = 7;
  localparam int SADDR_W   = 5;
  localparam logic [4:0] LAST_IDX = 5'd23;

  localparam logic [1:0] ACT_LOAD_FIELD = 2'd0;
  localparam logic [1:0] ACT_LOAD_SPIN  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE    = 2'd2;

  localparam logic [1:0] REG_KAPPA = 2'd0;
  localparam logic [1:0] REG_CSW   = 2'd1;
  localparam logic [1:0] REG_BASIS = 2'd2;

  // [basis][out spin][matrix]: bits 1..0 source spin, bits 3..2 coefficient
  // (0: +1, 1: -1, 2: +i, 3: -i)
  localparam logic [3:0] PATTERN [0:1][0:3][0:5] = '{
    '{ '{4'd9,  4'd1, 4'd8,  4'd15, 4'd7, 4'd14},
       '{4'd8,  4'd4, 4'd13, 4'd14, 4'd2, 4'd11},
       '{4'd11, 4'd3, 4'd10, 4'd13, 4'd5, 4'd12},
       '{4'd10, 4'd6, 4'd15, 4'd12, 4'd0, 4'd9} },
    '{ '{4'd9,  4'd1, 4'd8,  4'd13, 4'd5, 4'd12},
       '{4'd8,  4'd4, 4'd13, 4'd12, 4'd0, 4'd9},
       '{4'd11, 4'd3, 4'd10, 4'd11, 4'd3, 4'd10},
       '{4'd10, 4'd6, 4'd15, 4'd10, 4'd6, 4'd15} }
  };

  typedef struct packed {
    logic [1:0]               action;
    logic [2:0]               tensor_select;
    logic [4:0]               element_index;
    logic signed [DATA_W-1:0] load_value;
  } in_t;

  typedef struct packed {
    logic [4:0]                out_index;
    logic signed [VALUE_W-1:0] out_value;
    logic                      saturated;
    logic                      last_of_site;
  } out_t;

  typedef struct packed {
    logic               wr_field;
    logic               wr_spin;
    logic [FADDR_W-1:0] f_addr;
    logic [SADDR_W-1:0] s_addr;
    logic               issue;
    logic               tgt;
    logic               neg;
    logic               acc_clr;
    logic               smul_start;
    logic               smul_out;
    logic               k_load;
    logic               t_load;
    logic               part;
    logic               emit;
    logic [4:0]         idx;
  } cmd_t;

  typedef struct packed {
    logic smul_done;
    logic basis;
  } sts_t;

endpackage

// File: rtl/cts_smul.sv
// Signed serial multiplier, one 8-bit digit of the second operand per cycle.
module cts_smul #(
  parameter int W = cts_pkg::MUL_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic                  done,
  output logic signed [2*W-1:0] p
);

  localparam int STEPS = W / 8;
  localparam int CW    = $clog2(STEPS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic signed [W-1:0]   a_r;
  logic [W-1:0]          b_r;
  logic signed [2*W-1:0] p_r;

  logic [7:0]            chunk;
  logic signed [8:0]     cext;
  logic signed [W+8:0]   term;
  logic signed [2*W-1:0] p_nxt;

  always_comb begin
    chunk = b_r[W-1 -: 8];
    // top digit carries the sign, the rest are unsigned
    cext  = (cnt_r == CW'(STEPS)) ? {chunk[7], chunk} : {1'b0, chunk};
    term  = a_r * cext;
    p_nxt = (p_r <<< 8) + (2*W)'(term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= p_nxt;
      b_r <= b_r << 8;
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// File: rtl/cts_dp.sv
// Datapath: stores, product pipeline, accumulators, rounding and output register.
module cts_dp #(
  parameter int FRAC_BITS = cts_pkg::FRAC_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cts_pkg::in_t                  in_item,
  input  cts_pkg::cmd_t                 cmd,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [cts_pkg::DATA_W-1:0]    cfg_wdata,
  output cts_pkg::sts_t                 sts,
  output logic                          out_valid,
  output cts_pkg::out_t                 out_item
);

  localparam int DW  = cts_pkg::DATA_W;
  localparam int VW  = cts_pkg::VALUE_W;
  localparam int MW  = cts_pkg::MUL_W;
  localparam int AW  = cts_pkg::ACC_W;
  localparam int RW  = cts_pkg::RND_W;
  localparam int NF  = cts_pkg::NUM_MAT * cts_pkg::MAT_SIZE;
  localparam int NS  = cts_pkg::SPIN_SIZE;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (FRAC_BITS - 1);

  // round half up, shift out fraction, clip to VW; returns {clipped, value}
  function automatic logic [VW:0] rnd_sat(input logic signed [RW-1:0] x);
    logic signed [RW-1:0] r;
    logic [RW-VW:0]       hi;
    r  = (x + HALF) >>> FRAC_BITS;
    hi = r[RW-1:VW-1];
    if (hi == '0 || hi == '1) begin
      rnd_sat = {1'b0, r[VW-1:0]};
    end else if (r[RW-1]) begin
      rnd_sat = {1'b1, 1'b1, {(VW-1){1'b0}}};
    end else begin
      rnd_sat = {1'b1, 1'b0, {(VW-1){1'b1}}};
    end
  endfunction

  logic signed [DW-1:0] kappa_r;
  logic signed [DW-1:0] csw_r;
  logic                 basis_r;

  logic [DW-1:0]        fmem [0:NF-1];
  logic [DW-1:0]        smem [0:NS-1];
  logic [NF-1:0]        fvalid_r;
  logic [NS-1:0]        svalid_r;
  logic [DW-1:0]        fd_r;
  logic [DW-1:0]        sd_r;
  logic                 fv_r;
  logic                 sv_r;

  logic                 iss1_r, tgt1_r, neg1_r;
  logic                 iss2_r, tgt2_r, neg2_r;
  logic signed [2*DW-1:0] prod_r;
  logic signed [AW-1:0] acc0_r, acc1_r;
  logic signed [AW-1:0] addend;

  logic signed [VW-1:0] k_r, t_r;
  logic                 kflag_r, tflag_r;

  logic signed [MW-1:0]   ma, mb;
  logic                   mdone;
  logic signed [2*MW-1:0] mp;

  logic signed [RW-1:0] rnd_in;
  logic [VW:0]          rnd_out;
  logic signed [DW-1:0] opa, opb;

  logic                 out_valid_r;
  cts_pkg::out_t        out_item_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= '0;
      csw_r   <= '0;
      basis_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cts_pkg::REG_KAPPA: kappa_r <= cfg_wdata;
        cts_pkg::REG_CSW:   csw_r   <= cfg_wdata;
        cts_pkg::REG_BASIS: basis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stores; an entry never written reads as zero through its valid bit
  always_ff @(posedge clk) begin
    if (cmd.wr_field) fmem[cmd.f_addr] <= in_item.load_value;
    if (cmd.wr_spin)  smem[cmd.s_addr] <= in_item.load_value;
    fd_r <= fmem[cmd.f_addr];
    sd_r <= smem[cmd.s_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
      svalid_r <= '0;
      fv_r     <= 1'b0;
      sv_r     <= 1'b0;
    end else begin
      if (cmd.wr_field) fvalid_r[cmd.f_addr] <= 1'b1;
      if (cmd.wr_spin)  svalid_r[cmd.s_addr] <= 1'b1;
      fv_r <= fvalid_r[cmd.f_addr];
      sv_r <= svalid_r[cmd.s_addr];
    end
  end

  // product pipeline: read, multiply, accumulate
  always_comb begin
    opa    = fv_r ? fd_r : '0;
    opb    = sv_r ? sd_r : '0;
    addend = AW'(prod_r);
    if (neg2_r) addend = -addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss1_r <= 1'b0;
      iss2_r <= 1'b0;
    end else begin
      iss1_r <= cmd.issue;
      iss2_r <= iss1_r;
    end
  end

  always_ff @(posedge clk) begin
    tgt1_r <= cmd.tgt;
    neg1_r <= cmd.neg;
    tgt2_r <= tgt1_r;
    neg2_r <= neg1_r;
    prod_r <= opa * opb;
    if (cmd.acc_clr) begin
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (iss2_r) begin
      if (tgt2_r) acc1_r <= acc1_r + addend;
      else        acc0_r <= acc0_r + addend;
    end
  end

  // shared serial multiplier: kappa*cSW first, then T*K per component
  assign ma = cmd.smul_out ? MW'(t_r) : MW'(kappa_r);
  assign mb = cmd.smul_out ? MW'(k_r) : MW'(csw_r);

  cts_smul #(.W(MW)) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.smul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  always_comb begin
    if (cmd.t_load) rnd_in = cmd.part ? RW'(acc1_r) : RW'(acc0_r);
    else            rnd_in = RW'(mp);
    rnd_out = rnd_sat(rnd_in);
  end

  always_ff @(posedge clk) begin
    if (cmd.k_load) begin
      kflag_r <= rnd_out[VW];
      k_r     <= rnd_out[VW-1:0];
    end
    if (cmd.t_load) begin
      tflag_r <= rnd_out[VW];
      t_r     <= rnd_out[VW-1:0];
    end
    if (cmd.emit) begin
      out_item_r.out_index    <= cmd.idx;
      out_item_r.out_value    <= rnd_out[VW-1:0];
      out_item_r.saturated    <= rnd_out[VW] | kflag_r | tflag_r;
      out_item_r.last_of_site <= (cmd.idx == cts_pkg::LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  assign sts.smul_done = mdone;
  assign sts.basis     = basis_r;
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule

// File: rtl/cts_ctrl.sv
// Controller: accepts transactions and sequences the products of a compute.
module cts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  cts_pkg::in_t  in_item,
  input  cts_pkg::sts_t sts,
  output logic          busy,
  output cts_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_KMUL, S_KWAIT, S_ACC, S_DRAIN, S_TRND, S_OMUL, S_OWAIT
  } state_t;

  state_t     state_r;
  logic [1:0] s_r, c_r, k_r, j_r;
  logic [2:0] m_r;
  logic       part_r, drn_r;

  logic [3:0] pat;
  logic [1:0] src, coef;
  logic       is_pr;

  always_comb begin
    pat   = cts_pkg::PATTERN[sts.basis][s_r][m_r];
    src   = pat[1:0];
    coef  = pat[3:2];
    is_pr = !j_r[1];

    cmd            = '0;
    cmd.part       = part_r;
    cmd.idx        = 5'(s_r * cts_pkg::ROW_SIZE + c_r * 2 + part_r);
    cmd.tgt        = is_pr ? coef[1] : !coef[1];
    cmd.neg        = is_pr ? (coef[0] ^ j_r[0]) : (coef[0] ^ coef[1]);
    if (state_r == S_IDLE) begin
      cmd.f_addr = cts_pkg::FADDR_W'(in_item.tensor_select * cts_pkg::MAT_SIZE
                                     + in_item.element_index);
      cmd.s_addr = in_item.element_index;
    end else begin
      cmd.f_addr = cts_pkg::FADDR_W'(m_r * cts_pkg::MAT_SIZE + c_r * cts_pkg::ROW_SIZE
                                     + k_r * 2 + j_r[0]);
      cmd.s_addr = cts_pkg::SADDR_W'(src * cts_pkg::ROW_SIZE + k_r * 2
                                     + (j_r[0] ^ j_r[1]));
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.wr_field = (in_item.action == cts_pkg::ACT_LOAD_FIELD)
                         && (in_item.tensor_select < 3'(cts_pkg::NUM_MAT))
                         && (in_item.element_index < 5'(cts_pkg::MAT_SIZE));
          cmd.wr_spin  = (in_item.action == cts_pkg::ACT_LOAD_SPIN)
                         && (in_item.element_index < 5'(cts_pkg::SPIN_SIZE));
        end
      end
      S_KMUL:  cmd.smul_start = 1'b1;
      S_KWAIT: begin
        cmd.k_load  = sts.smul_done;
        cmd.acc_clr = sts.smul_done;
      end
      S_ACC:   cmd.issue = 1'b1;
      S_DRAIN: ;
      S_TRND:  cmd.t_load = 1'b1;
      S_OMUL: begin
        cmd.smul_start = 1'b1;
        cmd.smul_out   = 1'b1;
      end
      S_OWAIT: begin
        cmd.smul_out = 1'b1;
        cmd.emit     = sts.smul_done;
        cmd.acc_clr  = sts.smul_done & part_r;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s_r     <= '0;
      c_r     <= '0;
      m_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      part_r  <= 1'b0;
      drn_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start && in_item.action == cts_pkg::ACT_COMPUTE) state_r <= S_KMUL;
        end
        S_KMUL: state_r <= S_KWAIT;
        S_KWAIT: begin
          if (sts.smul_done) begin
            state_r <= S_ACC;
            s_r     <= '0;
            c_r     <= '0;
            m_r     <= '0;
            k_r     <= '0;
            j_r     <= '0;
            part_r  <= 1'b0;
          end
        end
        S_ACC: begin
          // advance product, then colour term, then matrix
          j_r <= j_r + 2'd1;
          if (j_r == 2'd3) begin
            if (k_r == 2'd2) begin
              k_r <= '0;
              if (m_r == 3'(cts_pkg::NUM_MAT - 1)) begin
                m_r     <= '0;
                drn_r   <= 1'b0;
                state_r <= S_DRAIN;
              end else begin
                m_r <= m_r + 3'd1;
              end
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_DRAIN: begin
          drn_r <= 1'b1;
          if (drn_r) state_r <= S_TRND;
        end
        S_TRND: state_r <= S_OMUL;
        S_OMUL: state_r <= S_OWAIT;
        S_OWAIT: begin
          if (sts.smul_done) begin
            if (!part_r) begin
              part_r  <= 1'b1;
              state_r <= S_TRND;
            end else begin
              part_r <= 1'b0;
              if (c_r == 2'd2) begin
                c_r <= '0;
                if (s_r == 2'd3) begin
                  state_r <= S_IDLE;
                end else begin
                  s_r     <= s_r + 2'd1;
                  state_r <= S_ACC;
                end
              end else begin
                c_r     <= c_r + 2'd1;
                state_r <= S_ACC;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/clover_term_site_multiply.sv
// Top level of the clover-term site multiply: controller, datapath and checks.
//
// channel   ports                               transaction taken when
// -------   ---------------------------------   -------------------------------
// input     start, busy, in_item                start high and busy low at clk
// result    out_valid, out_item                 every cycle out_valid is high
// config    cfg_we, cfg_index, cfg_wdata        cfg_we high at clk
//
// A load transaction leaves busy low; the next transaction can follow at
// once. A compute transaction holds busy while it runs; the serial multiplier
// works in MUL_W/8 digit steps. The block issues one 32x32 product per
// cycle in the accumulate phase: 72 products per spin/colour pair, and two
// serial T*K multiplies per pair.
// Results come one at a time, never in adjacent cycles; the receiver cannot
// stall them. Reset (rst_n low, synchronous) clears control, configuration
// and the valid bits of both stores, so unwritten entries read as zero.
module clover_term_site_multiply #(
  parameter int FRAC_BITS = cts_pkg::FRAC_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  cts_pkg::in_t               in_item,
  output logic                       out_valid,
  output cts_pkg::out_t              out_item,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cts_pkg::DATA_W-1:0] cfg_wdata
);

  cts_pkg::cmd_t cmd;
  cts_pkg::sts_t sts;

  // sequence loads and the product walk of a compute
  cts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // hold stores, accumulate, round and drive the result register
  cts_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // a compute transaction must take the block busy
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action == cts_pkg::ACT_COMPUTE) |=> busy)
    else $error("compute not taken busy");

  // results are separated by at least one idle cycle
  a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("adjacent results");

  // last-of-site marks only the final component
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_of_site) |-> (out_item.out_index == cts_pkg::LAST_IDX))
    else $error("last marker on wrong index");

  // a load does not produce a result in the next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action != cts_pkg::ACT_COMPUTE && !out_valid && !busy)
    |=> !out_valid)
    else $error("result after load");
`endif

endmodule

// File: tb/tb_clover_term_site_multiply.sv
// Testbench for the clover-term site multiply: directed and random transactions, self-checking.
`timescale 1ns / 1ps

module tb_clover_term_site_multiply;

  localparam int FB   = cts_pkg::FRAC_W;
  localparam int IN_W = $bits(cts_pkg::in_t);

  // Expected clover-term components, with the site state they are computed from.
  class clover_board;
    logic signed [31:0] field_mem [108];
    logic signed [31:0] spin_mem [24];
    logic signed [31:0] kappa;
    logic signed [31:0] csw;
    bit basis;
    cts_pkg::out_t pending[$];
    int errors;

    function new();
      foreach (field_mem[i]) field_mem[i] = '0;
      foreach (spin_mem[i]) spin_mem[i] = '0;
      kappa = '0;
      csw = '0;
      basis = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
        cts_pkg::REG_KAPPA: kappa = v;
        cts_pkg::REG_CSW:   csw = v;
        cts_pkg::REG_BASIS: basis = v[0];
        default: ;
      endcase
    endfunction

    // Round half up, then drop the fraction bits.
    function automatic logic signed [71:0] rescale(input logic signed [71:0] x);
      return (x + (72'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic logic signed [31:0] clip(input logic signed [71:0] x,
                                                inout bit flag);
      if (x > 72'sh7fffffff) begin
        flag = 1;
        return 32'sh7fffffff;
      end
      if (x < -72'sh80000000) begin
        flag = 1;
        return 32'sh80000000;
      end
      return x[31:0];
    endfunction

    // Note an accepted input transaction: update stores or queue 24 results.
    function void note_input(input cts_pkg::in_t it);
      logic signed [71:0] kw, ur, ui, vr, vi, pr, pi, a0, a1, tv, res;
      logic signed [31:0] kc, tc;
      logic [3:0] p;
      int t;
      bit kflag, flag;
      cts_pkg::out_t o;
      case (it.action)
        cts_pkg::ACT_LOAD_FIELD: begin
          if (it.tensor_select < 6 && it.element_index < 18)
            field_mem[it.tensor_select * 18 + it.element_index] = it.load_value;
        end
        cts_pkg::ACT_LOAD_SPIN: begin
          if (it.element_index < 24) spin_mem[it.element_index] = it.load_value;
        end
        cts_pkg::ACT_COMPUTE: begin
          kflag = 0;
          kw = 72'(kappa) * 72'(csw);
          kc = clip(rescale(kw), kflag);
          for (int s = 0; s < 4; s++) begin
            for (int c = 0; c < 3; c++) begin
              a0 = '0;
              a1 = '0;
              for (int m = 0; m < 6; m++) begin
                p = cts_pkg::PATTERN[basis][s][m];
                t = p[1:0];
                pr = '0;
                pi = '0;
                for (int k = 0; k < 3; k++) begin
                  ur = field_mem[m * 18 + c * 6 + k * 2];
                  ui = field_mem[m * 18 + c * 6 + k * 2 + 1];
                  vr = spin_mem[t * 6 + k * 2];
                  vi = spin_mem[t * 6 + k * 2 + 1];
                  pr = pr + ur * vr - ui * vi;
                  pi = pi + ur * vi + ui * vr;
                end
                case (p[3:2])
                  2'd0: begin a0 = a0 + pr; a1 = a1 + pi; end
                  2'd1: begin a0 = a0 - pr; a1 = a1 - pi; end
                  2'd2: begin a0 = a0 - pi; a1 = a1 + pr; end
                  default: begin a0 = a0 + pi; a1 = a1 - pr; end
                endcase
              end
              for (int part = 0; part < 2; part++) begin
                flag = kflag;
                tc = clip(rescale(part ? a1 : a0), flag);
                tv = tc;
                res = tv * 72'(kc);
                o.out_index = 5'(s * 6 + c * 2 + part);
                o.out_value = clip(rescale(res), flag);
                o.saturated = flag;
                o.last_of_site = (o.out_index == cts_pkg::LAST_IDX);
                pending.push_back(o);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Check one result against the oldest expectation.
    task check_result(input cts_pkg::out_t got);
      cts_pkg::out_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result index %0d", got.out_index));
        return;
      end
      e = pending.pop_front();
      if (got.out_index !== e.out_index)
        report($sformatf("index got %0d want %0d", got.out_index, e.out_index));
      if (got.out_value !== e.out_value)
        report($sformatf("value idx %0d got %h want %h", e.out_index,
                         got.out_value, e.out_value));
      if (got.saturated !== e.saturated)
        report($sformatf("saturated idx %0d got %b want %b", e.out_index,
                         got.saturated, e.saturated));
      if (got.last_of_site !== e.last_of_site)
        report($sformatf("last idx %0d got %b want %b", e.out_index,
                         got.last_of_site, e.last_of_site));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  cts_pkg::in_t in_item = '0;
  logic out_valid;
  cts_pkg::out_t out_item;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [cts_pkg::DATA_W-1:0] cfg_wdata = '0;

  clover_board board = new();
  int idle_pct = 0;

  clover_term_site_multiply dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Sample the handshakes at the edge; block outputs still hold pre-edge values.
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_input(in_item);
    if (rst_n && out_valid) board.check_result(out_item);
  end

  // Present one transaction and hold it until accepted; optionally idle afterwards.
  task send(input cts_pkg::in_t it);
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(negedge clk);
      if (!busy) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_item <= cts_pkg::in_t'(IN_W'({$urandom, $urandom}));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task send_fields(input logic [1:0] act, input int sel, input int el,
                   input logic [31:0] v);
    cts_pkg::in_t it;
    it.action = act;
    it.tensor_select = 3'(sel);
    it.element_index = 5'(el);
    it.load_value = v;
    send(it);
  endtask

  // Drop start and wait until all results are in and the block is idle.
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh01ffffff);
    endcase
  endfunction

  // Mostly well-formed loads with some computes; the rest is noise.
  task random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_fields(cts_pkg::ACT_LOAD_FIELD, $urandom_range(5), $urandom_range(17),
                  pick_value());
    else if (r < 80)
      send_fields(cts_pkg::ACT_LOAD_SPIN, $urandom_range(7), $urandom_range(23),
                  pick_value());
    else if (r < 89)
      send_fields(cts_pkg::ACT_COMPUTE, $urandom_range(7), $urandom_range(31), $urandom);
    else if (r < 93)
      send_fields(2'd3, $urandom_range(7), $urandom_range(31), $urandom);
    else
      send_fields(2'($urandom_range(1)), $urandom_range(6, 7), $urandom_range(18, 31),
                  $urandom);
  endtask

  initial begin
    logic [31:0] kap [8];
    logic [31:0] cs [8];
    kap = '{32'h00200000, 32'h7fffffff, 32'h80000000, 32'h00000000,
            32'h01000000, 32'hff000000, 32'h00000001, 32'h00400000};
    cs  = '{32'h01000000, 32'h7fffffff, 32'h80000000, 32'h01000000,
            32'h00800000, 32'h01800000, 32'hffffffff, 32'hfe000000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero stores, extremes, both bases, ignored items.
    send_fields(cts_pkg::ACT_COMPUTE, 0, 0, 0);
    drain();
    write_reg(cts_pkg::REG_KAPPA, 32'h01000000);
    write_reg(cts_pkg::REG_CSW, 32'h01000000);
    write_reg(cts_pkg::REG_BASIS, 32'd0);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 0, 0, 32'h7fffffff);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 5, 17, 32'h80000000);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 3, 7, 32'h01000000);
    send_fields(cts_pkg::ACT_LOAD_SPIN, 0, 0, 32'h7fffffff);
    send_fields(cts_pkg::ACT_LOAD_SPIN, 7, 23, 32'h80000000);
    send_fields(cts_pkg::ACT_LOAD_SPIN, 0, 13, 32'h00800000);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 6, 3, 32'h12345678);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 7, 31, 32'h12345678);
    send_fields(cts_pkg::ACT_LOAD_FIELD, 1, 18, 32'h12345678);
    send_fields(cts_pkg::ACT_LOAD_SPIN, 2, 24, 32'h12345678);
    send_fields(cts_pkg::ACT_LOAD_SPIN, 5, 31, 32'h12345678);
    send_fields(2'd3, 7, 31, 32'hffffffff);
    send_fields(cts_pkg::ACT_COMPUTE, 7, 31, 32'hffffffff);
    drain();
    write_reg(cts_pkg::REG_BASIS, 32'd1);
    send_fields(cts_pkg::ACT_COMPUTE, 0, 0, 0);
    drain();

    // Random phases over several register settings and idling modes.
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph < 3) ? 9 : (ph < 6) ? 77 : 0;
      write_reg(cts_pkg::REG_KAPPA, kap[ph]);
      write_reg(cts_pkg::REG_CSW, cs[ph]);
      write_reg(cts_pkg::REG_BASIS, 32'(ph[0]));
      for (int n = 0; n < 62; n++) random_item();
      send_fields(cts_pkg::ACT_COMPUTE, 0, 0, 0);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/cts_pkg.sv
rtl/cts_smul.sv
rtl/cts_dp.sv
rtl/cts_ctrl.sv
rtl/clover_term_site_multiply.sv
tb/tb_clover_term_site_multiply.sv
